/* rtl/lidar_range_frame_parser_top_defines.svh */
// Assertion macros shared by the frame parser RTL.
// Needs no other file; included by modules that carry assertions.
`ifndef LIDAR_RANGE_FRAME_PARSER_TOP_DEFINES_SVH
`define LIDAR_RANGE_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define LRFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrfp assertion failed");

// Next-cycle implication, disabled while reset is active.
`define LRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrfp assertion failed");

`endif

/* rtl/lrfp_pkg.sv */
// Types and constants of the rangefinder frame parser.
// Used by every module of the block; depends on nothing.
package lrfp_pkg;

    localparam logic [7:0]  HEADER_BYTE      = 8'h59;
    localparam logic [15:0] INVALID_STRENGTH = 16'hFFFF;
    localparam logic [16:0] TEMP_OFFSET      = 17'd2048;

    // Frame position counter values.
    localparam logic [3:0] POS_HUNT   = 4'd0;
    localparam logic [3:0] POS_HDR2   = 4'd1;
    localparam logic [3:0] POS_CKSUM  = 4'd8;
    localparam logic [3:0] POS_DATA0  = 4'd2;

    localparam int PAYLOAD_BYTES = 6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STRENGTH_FLOOR   = 2'd0;
    localparam logic [1:0] CFG_DISTANCE_CEILING = 2'd1;
    localparam logic [1:0] CFG_DISTANCE_FLOOR   = 2'd2;

    localparam logic [15:0] RST_STRENGTH_FLOOR   = 16'd100;
    localparam logic [15:0] RST_DISTANCE_CEILING = 16'd1100;
    localparam logic [15:0] RST_DISTANCE_FLOOR   = 16'd1;

    typedef struct packed {
        logic [15:0] strength_floor;
        logic [15:0] distance_ceiling;
        logic [15:0] distance_floor;
    } t_cfg;

    // Raw fields of one frame whose checksum matched.
    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] strength;
        logic [15:0] temp_raw;
    } t_frame;

endpackage

/* rtl/lidar_range_frame_parser_top.sv */
// Rangefinder serial frame parser, top level. One byte is taken per cycle while o_in_ready is high.
// A result is presented once the checksum byte of a good frame is accepted: that
// edge loads the frame capture register, then the output register loads it when empty or being drained.
// A byte is refused only while a finished frame waits behind a stalled output.
// Reset is synchronous, active low; it clears position, sum, history and the
// valid flags and loads the register defaults. Depends on lrfp_pkg and submodules.
module lidar_range_frame_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_distance_cm,
    output logic [15:0]         o_signal_strength,
    output logic signed [16:0]  o_temperature_eighths,
    output logic signed [20:0]  o_velocity,
    output logic signed [24:0]  o_acceleration,
    output logic                o_ground_healthy
);

    lrfp_pkg::t_cfg     w_cfg;
    lrfp_pkg::t_frame   w_frame;
    logic               w_frame_valid;
    logic               w_take;
    logic               w_accept;

    // A pending frame must move on before another byte may complete a frame.
    assign o_in_ready = !w_frame_valid || w_take;
    assign w_accept   = i_in_valid && o_in_ready;

    lrfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lrfp_frame_asm u_asm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .i_take        (w_take),
        .o_frame_valid (w_frame_valid),
        .o_frame       (w_frame)
    );

    lrfp_result u_res (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (w_cfg),
        .i_frame_valid         (w_frame_valid),
        .i_frame               (w_frame),
        .o_take                (w_take),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_distance_cm         (o_distance_cm),
        .o_signal_strength     (o_signal_strength),
        .o_temperature_eighths (o_temperature_eighths),
        .o_velocity            (o_velocity),
        .o_acceleration        (o_acceleration),
        .o_ground_healthy      (o_ground_healthy)
    );

endmodule

/* rtl/lrfp_cfg_regs.sv */
// Configuration register file of the frame parser.
// Depends on lrfp_pkg.
module lrfp_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output lrfp_pkg::t_cfg      o_cfg
);

    lrfp_pkg::t_cfg r_cfg;

    // Decode the write; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strength_floor   <= lrfp_pkg::RST_STRENGTH_FLOOR;
            r_cfg.distance_ceiling <= lrfp_pkg::RST_DISTANCE_CEILING;
            r_cfg.distance_floor   <= lrfp_pkg::RST_DISTANCE_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lrfp_pkg::CFG_STRENGTH_FLOOR:   r_cfg.strength_floor   <= i_cfg_data;
                lrfp_pkg::CFG_DISTANCE_CEILING: r_cfg.distance_ceiling <= i_cfg_data;
                lrfp_pkg::CFG_DISTANCE_FLOOR:   r_cfg.distance_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/lrfp_frame_asm.sv */
// Header hunt, byte collection and checksum check of the frame parser.
// Depends on lrfp_pkg and the assertion macro header.
`include "lidar_range_frame_parser_top_defines.svh"

module lrfp_frame_asm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_take,
    output logic                o_frame_valid,
    output lrfp_pkg::t_frame    o_frame
);

    logic [3:0]             r_pos;
    logic [3:0]             n_pos;
    logic [7:0]             r_sum;
    logic [7:0]             n_sum;
    logic [7:0]             r_bytes [lrfp_pkg::PAYLOAD_BYTES];
    logic                   r_fv;
    lrfp_pkg::t_frame       r_frame;
    logic                   w_good;
    logic [3:0]             w_slot_full;
    logic [2:0]             w_slot;

    assign w_slot_full = r_pos - lrfp_pkg::POS_DATA0;
    assign w_slot      = w_slot_full[2:0];

    // Next position and running sum for the accepted byte.
    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        w_good = 1'b0;
        if (r_pos == lrfp_pkg::POS_HUNT) begin
            if (i_rx_byte == lrfp_pkg::HEADER_BYTE) begin
                n_sum = i_rx_byte;
                n_pos = lrfp_pkg::POS_HDR2;
            end
        end else if (r_pos == lrfp_pkg::POS_HDR2) begin
            if (i_rx_byte == lrfp_pkg::HEADER_BYTE) begin
                n_sum = r_sum + i_rx_byte;
                n_pos = lrfp_pkg::POS_DATA0;
            end else begin
                n_pos = lrfp_pkg::POS_HUNT;
            end
        end else if (r_pos < lrfp_pkg::POS_CKSUM) begin
            n_sum = r_sum + i_rx_byte;
            n_pos = r_pos + 4'd1;
        end else begin
            // Checksum byte, or a position that cannot occur: back to hunting.
            w_good = (r_pos == lrfp_pkg::POS_CKSUM) && (i_rx_byte == r_sum);
            n_pos  = lrfp_pkg::POS_HUNT;
        end
    end

    // Control state: position, sum and the pending-frame flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= lrfp_pkg::POS_HUNT;
            r_sum <= 8'd0;
            r_fv  <= 1'b0;
        end else begin
            if (i_take) begin
                r_fv <= 1'b0;
            end
            if (i_accept) begin
                r_pos <= n_pos;
                r_sum <= n_sum;
                if (w_good) begin
                    r_fv <= 1'b1;
                end
            end
        end
    end

    // Payload bytes and the captured frame fields.
    always_ff @(posedge i_clk) begin
        if (i_accept && r_pos >= lrfp_pkg::POS_DATA0 && r_pos < lrfp_pkg::POS_CKSUM) begin
            r_bytes[w_slot] <= i_rx_byte;
        end
        if (i_accept && w_good) begin
            r_frame.distance <= {r_bytes[1], r_bytes[0]};
            r_frame.strength <= {r_bytes[2], r_bytes[3]};
            r_frame.temp_raw <= {r_bytes[4], r_bytes[5]};
        end
    end

    assign o_frame_valid = r_fv;
    assign o_frame       = r_frame;

    `LRFP_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= lrfp_pkg::POS_CKSUM)
    `LRFP_ASSERT_NEXT(a_pending_kept, i_clk, i_rst_n, r_fv && !i_take, r_fv)
    `LRFP_ASSERT_NEXT(a_cksum_restart, i_clk, i_rst_n,
        i_accept && r_pos == lrfp_pkg::POS_CKSUM, r_pos == lrfp_pkg::POS_HUNT)
    `LRFP_ASSERT_NEXT(a_frame_from_cksum, i_clk, i_rst_n, !r_fv,
        !r_fv || ($past(i_accept) && $past(r_pos) == lrfp_pkg::POS_CKSUM))

endmodule

/* rtl/lrfp_result.sv */
// Result computation and output register of the frame parser: temperature,
// rates from the previous frame, health flag. Depends on lrfp_pkg.
module lrfp_result (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrfp_pkg::t_cfg      i_cfg,
    input  logic                i_frame_valid,
    input  lrfp_pkg::t_frame    i_frame,
    output logic                o_take,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_distance_cm,
    output logic [15:0]         o_signal_strength,
    output logic signed [16:0]  o_temperature_eighths,
    output logic signed [20:0]  o_velocity,
    output logic signed [24:0]  o_acceleration,
    output logic                o_ground_healthy
);

    logic                 r_out_valid;
    logic [15:0]          r_prev_dist;
    logic signed [20:0]   r_prev_vel;
    logic [15:0]          r_dist;
    logic [15:0]          r_str;
    logic signed [16:0]   r_temp;
    logic signed [20:0]   r_vel;
    logic signed [24:0]   r_acc;
    logic                 r_healthy;
    logic signed [20:0]   w_ddist;
    logic signed [20:0]   w_vel;
    logic signed [24:0]   w_dvel;
    logic signed [24:0]   w_acc;
    logic signed [16:0]   w_temp;
    logic                 w_healthy;
    logic                 w_take;

    // The output register loads a pending frame whenever it is empty or being drained.
    assign w_take = i_frame_valid && (!r_out_valid || i_out_ready);

    // Times ten as shift-and-add.
    assign w_ddist = $signed({5'd0, i_frame.distance}) - $signed({5'd0, r_prev_dist});
    assign w_vel   = (w_ddist <<< 3) + (w_ddist <<< 1);
    assign w_dvel  = 25'(w_vel) - 25'(r_prev_vel);
    assign w_acc   = (w_dvel <<< 3) + (w_dvel <<< 1);
    assign w_temp  = $signed({1'b0, i_frame.temp_raw}) - $signed(lrfp_pkg::TEMP_OFFSET);

    assign w_healthy = (i_frame.strength != lrfp_pkg::INVALID_STRENGTH) &&
                       (i_frame.strength >= i_cfg.strength_floor) &&
                       (i_frame.distance <= i_cfg.distance_ceiling) &&
                       (i_frame.distance > i_cfg.distance_floor);

    // Control state and the history used for the rates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_dist <= 16'd0;
            r_prev_vel  <= 21'sd0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_prev_dist <= i_frame.distance;
                r_prev_vel  <= w_vel;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dist    <= i_frame.distance;
            r_str     <= i_frame.strength;
            r_temp    <= w_temp;
            r_vel     <= w_vel;
            r_acc     <= w_acc;
            r_healthy <= w_healthy;
        end
    end

    assign o_take                = w_take;
    assign o_out_valid           = r_out_valid;
    assign o_distance_cm         = r_dist;
    assign o_signal_strength     = r_str;
    assign o_temperature_eighths = r_temp;
    assign o_velocity            = r_vel;
    assign o_acceleration        = r_acc;
    assign o_ground_healthy      = r_healthy;

endmodule
